// File: rtl/avh_pkg.sv
// ----------------------------------------------------------------------------
// avh_pkg
// Shared codes, handle layout constants and control structs for the
// versioned handle allocator.
// ----------------------------------------------------------------------------
package avh_pkg;

   // operation codes
   localparam logic [1:0] MODE_CREATE   = 2'd0;
   localparam logic [1:0] MODE_VALIDATE = 2'd1;
   localparam logic [1:0] MODE_DESTROY  = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;

   // handle layout: free flag, 32-bit version, 31-bit slot
   localparam logic [63:0] VERSION_ONE = 64'h0000_0000_8000_0000;
   localparam logic [63:0] NOT_FREE    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] FREE_BIT    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] SLOT_MASK   = 64'h0000_0000_7FFF_FFFF;
   localparam int          VER_SHIFT   = 31;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic rd_stack;
      logic rd_table_req;
      logic rd_table_stack;
      logic execute;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pick_recycle;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/avh_ctrl.sv
// ----------------------------------------------------------------------------
// avh_ctrl
// Sequencer for one operation: accept, optional free stack read, table read,
// then execute once the result register can take the result.
// ----------------------------------------------------------------------------
module avh_ctrl
   import avh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_STACK = 3'b010,
      ST_TABLE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.pick_recycle) begin
                  cmd.rd_stack = 1'b1;
                  state_in     = ST_STACK;
               end else begin
                  cmd.rd_table_req = 1'b1;
                  state_in         = ST_TABLE;
               end
            end
         end
         ST_STACK: begin
            cmd.rd_table_stack = 1'b1;
            state_in           = ST_TABLE;
         end
         ST_TABLE: begin
            if (sts.out_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/avh_dp.sv
// ----------------------------------------------------------------------------
// avh_dp
// Handle table, free stack, counters, capacity register and result register.
// Reads are registered; execute writes the table and the stack together.
// ----------------------------------------------------------------------------
module avh_dp
   import avh_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type sts,
   input  logic [1:0]    req_mode,
   input  logic [63:0]   req_handle_in,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [10:0]   csr_capacity,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic          rsp_recycled,
   output logic [63:0]   rsp_handle_out,
   output logic [9:0]    rsp_slot_out,
   output logic [10:0]   rsp_live_count
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   // memories
   logic [63:0]      handle_mem [SLOTS];
   logic [IDX_W-1:0] stack_mem  [SLOTS];

   // control state
   logic [10:0]      capacity_ff;
   logic [CNT_W-1:0] free_depth_ff, free_depth_in;
   logic [CNT_W-1:0] high_water_ff, high_water_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic             rsp_valid_ff;

   // operation and read data registers
   logic [1:0]       mode_ff;
   logic [63:0]      handle_ff;
   logic             recycle_ff;
   logic [63:0]      table_q_ff;
   logic [IDX_W-1:0] stack_q_ff;

   // result registers
   logic [1:0]       rsp_status_ff;
   logic             rsp_recycled_ff;
   logic [63:0]      rsp_handle_out_ff;
   logic [9:0]       rsp_slot_out_ff;
   logic [10:0]      rsp_live_count_ff;

   // execute stage signals
   logic [1:0]       status_in;
   logic             recycled_in;
   logic [63:0]      hout_in;
   logic [IDX_W-1:0] slot_in;
   logic             tbl_we;
   logic [IDX_W-1:0] tbl_wa;
   logic [63:0]      tbl_wd;
   logic             stk_we;
   logic [IDX_W-1:0] tbl_ra;
   logic [30:0]      slot_field;
   logic             is_match;
   logic             is_full;
   logic [31:0]      ver_next;

   assign csr_ready = 1'b1;

   // status towards the controller
   assign sts.pick_recycle = (req_mode == MODE_CREATE) && (free_depth_ff != '0);
   assign sts.out_free     = !rsp_valid_ff || !rsp_stall;

   // table read address: from the request or from the stack top
   assign tbl_ra = cmd.rd_table_stack ? stack_q_ff : IDX_W'(req_handle_in & SLOT_MASK);

   // lookup against the stored word
   assign slot_field = 31'(handle_ff & SLOT_MASK);
   assign is_match   = (32'(slot_field) < 32'(high_water_ff)) && !handle_ff[63]
                       && (table_q_ff == handle_ff);
   assign is_full    = (32'(high_water_ff) >= 32'(capacity_ff))
                       || (32'(high_water_ff) >= SLOTS);
   assign ver_next   = 32'(handle_ff >> VER_SHIFT) + 32'd1;

   // operation result and state updates
   always_comb begin
      status_in     = STATUS_MISMATCH;
      recycled_in   = 1'b0;
      hout_in       = '0;
      slot_in       = '0;
      tbl_we        = 1'b0;
      tbl_wa        = IDX_W'(slot_field);
      tbl_wd        = '0;
      stk_we        = 1'b0;
      free_depth_in = free_depth_ff;
      high_water_in = high_water_ff;
      live_in       = live_ff;
      case (mode_ff)
         MODE_CREATE: begin
            if (recycle_ff) begin
               tbl_we        = 1'b1;
               tbl_wa        = stack_q_ff;
               tbl_wd        = table_q_ff & NOT_FREE;
               hout_in       = table_q_ff & NOT_FREE;
               slot_in       = stack_q_ff;
               recycled_in   = 1'b1;
               status_in     = STATUS_OK;
               free_depth_in = free_depth_ff - CNT_W'(1);
               live_in       = live_ff + CNT_W'(1);
            end else if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               tbl_we        = 1'b1;
               tbl_wa        = IDX_W'(high_water_ff);
               tbl_wd        = 64'(high_water_ff) | VERSION_ONE;
               hout_in       = 64'(high_water_ff) | VERSION_ONE;
               slot_in       = IDX_W'(high_water_ff);
               status_in     = STATUS_OK;
               high_water_in = high_water_ff + CNT_W'(1);
               live_in       = live_ff + CNT_W'(1);
            end
         end
         MODE_VALIDATE: begin
            if (is_match) begin
               slot_in   = IDX_W'(slot_field);
               status_in = STATUS_OK;
            end
         end
         MODE_DESTROY: begin
            if (is_match && (32'(free_depth_ff) < SLOTS)) begin
               tbl_we        = 1'b1;
               tbl_wd        = FREE_BIT | (64'(ver_next) << VER_SHIFT)
                               | (handle_ff & SLOT_MASK);
               stk_we        = 1'b1;
               free_depth_in = free_depth_ff + CNT_W'(1);
               if (live_ff != '0) begin
                  live_in = live_ff - CNT_W'(1);
               end
               slot_in   = IDX_W'(slot_field);
               status_in = STATUS_OK;
            end
         end
         default: ;
      endcase
   end

   // handle table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.execute && tbl_we) begin
         handle_mem[tbl_wa] <= tbl_wd;
      end
      if (cmd.rd_table_req || cmd.rd_table_stack) begin
         table_q_ff <= handle_mem[tbl_ra];
      end
   end

   // free stack: push at depth, read below depth
   always_ff @(posedge clock) begin
      if (cmd.execute && stk_we) begin
         stack_mem[IDX_W'(free_depth_ff)] <= IDX_W'(slot_field);
      end
      if (cmd.rd_stack) begin
         stack_q_ff <= stack_mem[IDX_W'(free_depth_ff - CNT_W'(1))];
      end
   end

   // operation capture on transfer
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff    <= req_mode;
         handle_ff  <= req_handle_in;
         recycle_ff <= sts.pick_recycle;
      end
   end

   // counters and capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= 11'd1024;
         free_depth_ff <= '0;
         high_water_ff <= '0;
         live_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
         if (cmd.execute) begin
            free_depth_ff <= free_depth_in;
            high_water_ff <= high_water_in;
            live_ff       <= live_in;
         end
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status_ff     <= status_in;
         rsp_recycled_ff   <= recycled_in;
         rsp_handle_out_ff <= hout_in;
         rsp_slot_out_ff   <= 10'(slot_in);
         rsp_live_count_ff <= 11'(live_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_recycled   = rsp_recycled_ff;
   assign rsp_handle_out = rsp_handle_out_ff;
   assign rsp_slot_out   = rsp_slot_out_ff;
   assign rsp_live_count = rsp_live_count_ff;

endmodule

// File: rtl/versioned_handle_allocator.sv
// ----------------------------------------------------------------------------
// versioned_handle_allocator: one operation at a time, result registered
// a create from the free stack reads the stack top, then the table; others read the table
// no new request is taken until the operation executes into the result register
// sync reset clears counters, sets capacity to 1024; memories are not cleared
// ----------------------------------------------------------------------------
module versioned_handle_allocator
   import avh_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_handle_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_recycled,
   output logic [63:0] rsp_handle_out,
   output logic [9:0]  rsp_slot_out,
   output logic [10:0] rsp_live_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_capacity
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // sequencer
   avh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, counters and result register
   avh_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_mode       (req_mode),
      .req_handle_in  (req_handle_in),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_recycled   (rsp_recycled),
      .rsp_handle_out (rsp_handle_out),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_live_count (rsp_live_count)
   );

endmodule

// File: rtl/avh_checker.sv
// ----------------------------------------------------------------------------
// avh_checker
// Port-level checks for the versioned handle allocator, bound to the top.
// ----------------------------------------------------------------------------
module avh_checker
   import avh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_recycled,
   input logic [63:0] rsp_handle_out,
   input logic [9:0]  rsp_slot_out
);

   // one operation at a time: a transfer is followed by a stall
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while an operation was in flight");

   // failed operations carry no handle, slot or recycle flag
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK))
      |-> (rsp_handle_out == 64'd0 && rsp_slot_out == 10'd0 && !rsp_recycled))
      else $error("failed result carries handle or slot");

   // a recycled handle is live: successful and free flag clear
   a_recycle_live: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_recycled) |-> (rsp_status == STATUS_OK && !rsp_handle_out[63]))
      else $error("recycled handle not live");

   // a fresh create hands out version one
   a_fresh_version: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK && !rsp_recycled && rsp_handle_out != 64'd0)
      |-> (rsp_handle_out[63:31] == 33'd1))
      else $error("fresh handle without version one");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_handle_out)))
      else $error("stalled result changed");

endmodule

bind versioned_handle_allocator avh_checker u_avh_checker (.*);
